FILE: hdl/bpq_pkg.sv
// Shared types and constants for the bounded priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

    localparam int TAG_W         = 16;
    localparam int KEY_W         = 8;
    localparam int OCC_W         = 5;
    localparam int DEFAULT_DEPTH = 16;

    typedef enum logic
    {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } entry_t;

    // Per-cycle command to the cell row
    typedef struct packed
    {
        logic ins;   // place new entry in sorted position
        logic ext;   // drop head, everything shifts towards the head
    } cell_ctl_t;

endpackage

FILE: hdl/bpq_cell.sv
// One cell of the sorted queue row: holds a single entry.
`timescale 1ns / 1ps

module bpq_cell
    import bpq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  logic      occ,          // this cell currently holds a live entry
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_before,  // new entry goes at or before the left cell
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      new_ahead
);

    entry_t entry_reg;
    entry_t entry_next;

    // Strict compare keeps equal keys in arrival order
    assign new_ahead = !occ || (new_entry.key < entry_reg.key);
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (left_before)
            begin
                entry_next = left_entry;
            end
            else if (new_ahead)
            begin
                entry_next = new_entry;
            end
        end
        else if (ctl.ext)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

FILE: hdl/bounded_priority_queue_core.sv
// Top level of the bounded priority queue: cell row, count and result register.
`timescale 1ns / 1ps

// Bounded extract-min priority queue built as a row of QUEUE_DEPTH cells kept
// sorted by key, equal keys in arrival order, so the head cell always holds
// the entry to serve next. An enqueue is placed in its sorted position by all
// cells comparing against it at once, a dequeue returns the head and shifts
// the row one place towards it. One item can be accepted every cycle; the
// result register parts the two sides, and input stall rises only while a
// result is held and res_stall is high. An enqueue into a full queue is
// discarded with dropped set; a dequeue of an empty queue returns out_valid
// low with zero tag and key. occupancy carries the low five bits of the
// count after the item.

module bounded_priority_queue_core
    import bpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    // input items
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             command,
    input  logic [TAG_W-1:0] entry_tag,
    input  logic [KEY_W-1:0] entry_key,
    // result items
    output logic             res_valid,
    input  logic             res_stall,
    output logic             out_valid,
    output logic [TAG_W-1:0] out_tag,
    output logic [KEY_W-1:0] out_key,
    output logic             dropped,
    output logic             now_empty,
    output logic [OCC_W-1:0] occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             res_valid_reg;
    logic             out_valid_reg, out_valid_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [KEY_W-1:0] out_key_reg, out_key_next;
    logic             dropped_reg, dropped_next;
    logic             now_empty_reg;
    logic [OCC_W-1:0] occupancy_reg;
    logic [31:0]      count_wide;

    logic             accept;
    logic             is_deq;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    entry_t           new_entry;
    entry_t           cell_entry [QUEUE_DEPTH];
    logic             cell_before [QUEUE_DEPTH];
    logic             cell_occ [QUEUE_DEPTH];

    assign in_stall  = res_valid_reg && res_stall;
    assign accept    = in_valid && !in_stall;
    assign is_deq    = (command == CMD_DEQUEUE);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign new_entry.tag = entry_tag;
    assign new_entry.key = entry_key;

    assign ctl.ins = accept && !is_deq && !full;
    assign ctl.ext = accept && is_deq && !empty;

    // ---------------------------------------------------------------
    // Cell row: cell 0 is the head
    // ---------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_b;
            entry_t right_e;

            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_b = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_b = cell_before[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = cell_entry[gi];   // vacated, content irrelevant
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            bpq_cell u_cell
            (
                .clk         (clk),
                .ctl         (ctl),
                .occ         (cell_occ[gi]),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_before (left_b),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .new_ahead   (cell_before[gi])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Count and result of the accepted item
    // ---------------------------------------------------------------
    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = 1'b0;
        out_tag_next   = '0;
        out_key_next   = '0;
        dropped_next   = 1'b0;
        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.ext)
        begin
            count_next     = count_reg - CNT_W'(1);
            out_valid_next = 1'b1;
            out_tag_next   = cell_entry[0].tag;
            out_key_next   = cell_entry[0].key;
        end
        else if (accept && !is_deq)
        begin
            dropped_next = 1'b1;   // enqueue into a full queue
        end
    end

    assign count_wide = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded only with an accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_valid_reg <= out_valid_next;
            out_tag_reg   <= out_tag_next;
            out_key_reg   <= out_key_next;
            dropped_reg   <= dropped_next;
            now_empty_reg <= (count_next == '0);
            occupancy_reg <= count_wide[OCC_W-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_key   = out_key_reg;
    assign dropped   = dropped_reg;
    assign now_empty = now_empty_reg;
    assign occupancy = occupancy_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_extract_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ext |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("dequeue did not reduce count by one");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> cell_entry[0].key <= cell_entry[1].key)
        else $error("head cell does not hold the smallest key");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && dropped_reg |-> full)
        else $error("drop reported while queue not full");

endmodule
